[src/gffs_pkg.sv]
// Package: shared constants, configuration register indexes, sequencer states and size struct.
package gffs_pkg;

  localparam int MAX_COLS_DEF = 16;
  localparam int MAX_ROWS_DEF = 16;

  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int SIZE_W     = 7;
  localparam int COUNT_W    = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUAL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;

  localparam logic [4:0] COLUMNS_RST = 5'd16;
  localparam logic [4:0] ROWS_RST    = 5'd16;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_SEARCH,
    ST_COUNT,
    ST_DONE
  } state_t;

  // Effective plate size after saturation at the store size.
  typedef struct packed {
    logic              dual;
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
    logic [3:0]        resv;
  } size_cfg_t;

endpackage

[src/gffs_in_if.sv]
// Interface: input word channel carrying one write or search command.
interface gffs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       plate_sel;
  logic [3:0] cell_col;
  logic [3:0] cell_row;
  logic       cell_full;

  modport source (output valid, cmd, plate_sel, cell_col, cell_row, cell_full, input ready);
  modport sink   (input valid, cmd, plate_sel, cell_col, cell_row, cell_full, output ready);
endinterface

[src/gffs_out_if.sv]
// Interface: result word channel with search hit and plate counts.
interface gffs_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic       found_plate;
  logic [3:0] found_col;
  logic [3:0] found_row;
  logic [8:0] occupied_count;
  logic [8:0] free_count;

  modport source (output valid, found, found_plate, found_col, found_row, occupied_count,
                  free_count, input ready);
  modport sink   (input valid, found, found_plate, found_col, found_row, occupied_count,
                  free_count, output ready);
endinterface

[src/gffs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gffs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/gffs_cfg.sv]
// Configuration registers and saturation of the plate size to the store size.
module gffs_cfg #(
  parameter int MAX_COLS = gffs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gffs_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gffs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [gffs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output gffs_pkg::size_cfg_t                size
);

  logic [4:0] cols_r;
  logic [4:0] rows_r;
  logic       dual_r;
  logic [3:0] resv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= gffs_pkg::COLUMNS_RST;
      rows_r <= gffs_pkg::ROWS_RST;
      dual_r <= 1'b0;
      resv_r <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        gffs_pkg::CFG_COLUMNS:  cols_r <= cfg_wdata[4:0];
        gffs_pkg::CFG_ROWS:     rows_r <= cfg_wdata[4:0];
        gffs_pkg::CFG_DUAL:     dual_r <= cfg_wdata[0];
        gffs_pkg::CFG_RESERVED: resv_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign size.dual = dual_r;
  assign size.resv = resv_r;
  assign size.cols = (int'(cols_r) > MAX_COLS) ? gffs_pkg::SIZE_W'(MAX_COLS)
                                               : gffs_pkg::SIZE_W'(cols_r);
  assign size.rows = (int'(rows_r) > MAX_ROWS) ? gffs_pkg::SIZE_W'(MAX_ROWS)
                                               : gffs_pkg::SIZE_W'(rows_r);

endmodule

[src/gffs_row_unit.sv]
// Shared row unit: first free column and occupied count of one row word.
module gffs_row_unit #(
  parameter int MAX_COLS = gffs_pkg::MAX_COLS_DEF
) (
  input  logic [MAX_COLS-1:0]               row_word,
  input  logic                              row_valid,
  input  logic [gffs_pkg::SIZE_W-1:0]       ncols,
  output logic                              any_free,
  output logic [3:0]                        free_col,
  output logic [$clog2(MAX_COLS+1)-1:0]     occ_cnt
);

  localparam int OCW = $clog2(MAX_COLS + 1);

  logic [MAX_COLS-1:0] mask;
  logic [MAX_COLS-1:0] occ;
  logic [MAX_COLS-1:0] freev;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      mask[c] = (c < int'(ncols));
    end
  end

  // A row that was never written since reset reads as all empty.
  assign occ   = row_word & {MAX_COLS{row_valid}} & mask;
  assign freev = ~occ & mask;
  assign any_free = |freev;

  always_comb begin
    free_col = 4'd0;
    for (int c = MAX_COLS - 1; c >= 0; c--) begin
      if (freev[c]) begin
        free_col = 4'(c);
      end
    end
  end

  always_comb begin
    occ_cnt = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      occ_cnt = occ_cnt + OCW'(occ[c]);
    end
  end

endmodule

[src/grid_first_free_cell_search_unit.sv]
// Top level: occupancy map of two plates with first-free-cell search and cell counts.
//
//   channel | dir | handshake          | contents
//   in_if   | in  | valid/ready        | cmd, plate_sel, cell_col, cell_row, cell_full
//   out_if  | out | valid/ready        | found, found_plate/col/row, occupied/free count
//   cfg_*   | in  | cfg_we, no wait    | cfg_idx selects register, cfg_wdata its value
//
// One word at a time; in_if.ready is high only in the idle state, which is the accept cycle.
// An in-range write reads and writes back its row. A search reads rows back to back from the
// start plate and moves to the other plate when dual mode is set and no hit was found.
// Both then run a count pass over the rows in use of the selected plate and load the output.
// The occupancy RAM delivers one row per cycle to the row unit.
// Reset empties the map at once through per-row valid flags; there is no clearing pass.
// A finished word waits in the output register and the next word is accepted meanwhile.
module grid_first_free_cell_search_unit #(
  parameter int MAX_COLS = gffs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gffs_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gffs_in_if.sink                         in_if,
  gffs_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [gffs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gffs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = 2 * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int OCW   = $clog2(MAX_COLS + 1);
  localparam int ACW   = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int CW    = gffs_pkg::COUNT_W;

  gffs_pkg::size_cfg_t size;

  gffs_pkg::state_t state_r, state_nxt;

  logic             sel_r, sel_nxt;
  logic [3:0]       col_r, col_nxt;
  logic             full_r, full_nxt;

  logic             iss_plate_r, iss_plate_nxt;
  logic [RCW-1:0]   iss_row_r, iss_row_nxt;
  logic             pass_r, pass_nxt;

  logic             rdv_r, rdv_nxt;
  logic             tag_plate_r;
  logic [RCW-1:0]   tag_row_r;
  logic             tag_vld_r;

  logic             start_plate_r, start_plate_nxt;
  logic             hit_r, hit_nxt;
  logic             hit_plate_r, hit_plate_nxt;
  logic [3:0]       hit_col_r, hit_col_nxt;
  logic [3:0]       hit_row_r, hit_row_nxt;
  logic [ACW-1:0]   acc_r, acc_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             found_r, found_nxt;
  logic             found_plate_r, found_plate_nxt;
  logic [3:0]       found_col_r, found_col_nxt;
  logic [3:0]       found_row_r, found_row_nxt;
  logic [CW-1:0]    occ_out_r, occ_out_nxt;
  logic [CW-1:0]    free_out_r, free_out_nxt;

  logic [DEPTH-1:0] row_vld_r, row_vld_nxt;

  logic [AW-1:0]       rd_addr;
  logic [MAX_COLS-1:0] rdata;
  logic [MAX_COLS-1:0] wdata;
  logic                ram_we;

  logic                any_free;
  logic [3:0]          free_col;
  logic [OCW-1:0]      occ_cnt;

  logic [RCW-1:0]   nr;
  logic [RCW-1:0]   row0_p0;
  logic             can_issue;
  logic             accept;
  logic             wr_in_range;
  logic [ACW-1:0]   cap;
  logic [ACW-1:0]   free_full;

  gffs_cfg #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .size      (size)
  );

  gffs_ram #(.WIDTH(MAX_COLS), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  gffs_row_unit #(.MAX_COLS(MAX_COLS)) u_row (
    .row_word  (rdata),
    .row_valid (tag_vld_r),
    .ncols     (size.cols),
    .any_free  (any_free),
    .free_col  (free_col),
    .occ_cnt   (occ_cnt)
  );

  assign nr = RCW'(size.rows);
  // Plate 0 starts below the reserved rows; with all rows reserved it has none to scan.
  assign row0_p0 = (int'(size.resv) >= int'(size.rows)) ? nr : RCW'(size.resv);
  assign can_issue = (iss_row_r < nr);
  assign rd_addr = AW'(iss_row_r) + (iss_plate_r ? AW'(MAX_ROWS) : AW'(0));

  assign in_if.ready = (state_r == gffs_pkg::ST_IDLE);
  assign accept = in_if.valid && in_if.ready;
  assign wr_in_range = (int'(in_if.cell_col) < MAX_COLS) && (int'(in_if.cell_row) < MAX_ROWS);

  assign cap = ACW'(size.cols) * ACW'(size.rows);
  assign free_full = cap - acc_r;

  // Read-modify-write of one row word: only the addressed column changes.
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      wdata[c] = (int'(col_r) == c) ? full_r : (rdata[c] & tag_vld_r);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    sel_nxt         = sel_r;
    col_nxt         = col_r;
    full_nxt        = full_r;
    iss_plate_nxt   = iss_plate_r;
    iss_row_nxt     = iss_row_r;
    pass_nxt        = pass_r;
    rdv_nxt         = 1'b0;
    start_plate_nxt = start_plate_r;
    hit_nxt         = hit_r;
    hit_plate_nxt   = hit_plate_r;
    hit_col_nxt     = hit_col_r;
    hit_row_nxt     = hit_row_r;
    acc_nxt         = acc_r;
    out_valid_nxt   = out_valid_r;
    found_nxt       = found_r;
    found_plate_nxt = found_plate_r;
    found_col_nxt   = found_col_r;
    found_row_nxt   = found_row_r;
    occ_out_nxt     = occ_out_r;
    free_out_nxt    = free_out_r;
    row_vld_nxt     = row_vld_r;
    ram_we          = 1'b0;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      gffs_pkg::ST_IDLE: begin
        if (accept) begin
          sel_nxt       = in_if.plate_sel;
          col_nxt       = in_if.cell_col;
          full_nxt      = in_if.cell_full;
          hit_nxt       = 1'b0;
          hit_plate_nxt = 1'b0;
          hit_col_nxt   = 4'd0;
          hit_row_nxt   = 4'd0;
          acc_nxt       = '0;
          if (in_if.cmd == gffs_pkg::CMD_SEARCH) begin
            iss_plate_nxt = start_plate_r;
            iss_row_nxt   = start_plate_r ? RCW'(0) : row0_p0;
            pass_nxt      = 1'b0;
            state_nxt     = gffs_pkg::ST_SEARCH;
          end else if (wr_in_range) begin
            iss_plate_nxt = in_if.plate_sel;
            iss_row_nxt   = RCW'(in_if.cell_row);
            state_nxt     = gffs_pkg::ST_WR_RD;
          end else begin
            iss_plate_nxt = in_if.plate_sel;
            iss_row_nxt   = '0;
            state_nxt     = gffs_pkg::ST_COUNT;
          end
        end
      end

      gffs_pkg::ST_WR_RD: begin
        state_nxt = gffs_pkg::ST_WR_WB;
      end

      gffs_pkg::ST_WR_WB: begin
        ram_we               = 1'b1;
        row_vld_nxt[rd_addr] = 1'b1;
        iss_plate_nxt        = sel_r;
        iss_row_nxt          = '0;
        state_nxt            = gffs_pkg::ST_COUNT;
      end

      gffs_pkg::ST_SEARCH: begin
        // Rows are read back to back; the first returned row with a free cell wins and
        // rows still in flight behind it are dropped.
        if (rdv_r && any_free) begin
          hit_nxt         = 1'b1;
          hit_plate_nxt   = tag_plate_r;
          hit_col_nxt     = free_col;
          hit_row_nxt     = 4'(tag_row_r);
          start_plate_nxt = tag_plate_r;
          iss_plate_nxt   = sel_r;
          iss_row_nxt     = '0;
          state_nxt       = gffs_pkg::ST_COUNT;
        end else if (can_issue) begin
          rdv_nxt     = 1'b1;
          iss_row_nxt = iss_row_r + 1'b1;
        end else if (!pass_r && size.dual) begin
          pass_nxt      = 1'b1;
          iss_plate_nxt = ~iss_plate_r;
          iss_row_nxt   = iss_plate_r ? row0_p0 : RCW'(0);
        end else if (!rdv_r) begin
          iss_plate_nxt = sel_r;
          iss_row_nxt   = '0;
          state_nxt     = gffs_pkg::ST_COUNT;
        end
      end

      gffs_pkg::ST_COUNT: begin
        if (rdv_r) begin
          acc_nxt = acc_r + ACW'(occ_cnt);
        end
        if (can_issue) begin
          rdv_nxt     = 1'b1;
          iss_row_nxt = iss_row_r + 1'b1;
        end else if (!rdv_r) begin
          state_nxt = gffs_pkg::ST_DONE;
        end
      end

      gffs_pkg::ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          found_nxt       = hit_r;
          found_plate_nxt = hit_plate_r;
          found_col_nxt   = hit_col_r;
          found_row_nxt   = hit_row_r;
          occ_out_nxt     = (int'(acc_r) > int'(gffs_pkg::COUNT_SAT)) ? gffs_pkg::COUNT_SAT
                                                                     : CW'(acc_r);
          free_out_nxt    = (int'(free_full) > int'(gffs_pkg::COUNT_SAT)) ? gffs_pkg::COUNT_SAT
                                                                         : CW'(free_full);
          state_nxt       = gffs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gffs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gffs_pkg::ST_IDLE;
      rdv_r         <= 1'b0;
      pass_r        <= 1'b0;
      start_plate_r <= 1'b0;
      out_valid_r   <= 1'b0;
      row_vld_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      rdv_r         <= rdv_nxt;
      pass_r        <= pass_nxt;
      start_plate_r <= start_plate_nxt;
      out_valid_r   <= out_valid_nxt;
      row_vld_r     <= row_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r         <= sel_nxt;
    col_r         <= col_nxt;
    full_r        <= full_nxt;
    iss_plate_r   <= iss_plate_nxt;
    iss_row_r     <= iss_row_nxt;
    tag_plate_r   <= iss_plate_r;
    tag_row_r     <= iss_row_r;
    tag_vld_r     <= row_vld_r[rd_addr];
    hit_r         <= hit_nxt;
    hit_plate_r   <= hit_plate_nxt;
    hit_col_r     <= hit_col_nxt;
    hit_row_r     <= hit_row_nxt;
    acc_r         <= acc_nxt;
    found_r       <= found_nxt;
    found_plate_r <= found_plate_nxt;
    found_col_r   <= found_col_nxt;
    found_row_r   <= found_row_nxt;
    occ_out_r     <= occ_out_nxt;
    free_out_r    <= free_out_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.found          = found_r;
  assign out_if.found_plate    = found_plate_r;
  assign out_if.found_col      = found_col_r;
  assign out_if.found_row      = found_row_r;
  assign out_if.occupied_count = occ_out_r;
  assign out_if.free_count     = free_out_r;

endmodule

[dv/grid_first_free_cell_search_unit_test.sv]
// Testbench for the grid first-free-cell search unit: directed and random words checked against a predictor.
module grid_first_free_cell_search_unit_test;
  import gffs_pkg::*;

  localparam int NCOLS = MAX_COLS_DEF;
  localparam int NROWS = MAX_ROWS_DEF;

  typedef struct packed {
    logic               found;
    logic               plate;
    logic [3:0]         col;
    logic [3:0]         row;
    logic [COUNT_W-1:0] occupied;
    logic [COUNT_W-1:0] vacant;
  } cell_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gffs_in_if  in_ch ();
  gffs_out_if out_ch ();

  grid_first_free_cell_search_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predicted state of the block.
  bit           occ_map [2][NROWS][NCOLS];
  bit           start_plate_m = 1'b0;
  bit [4:0]     cols_reg = COLUMNS_RST;
  bit [4:0]     rows_reg = ROWS_RST;
  bit           dual_reg = 1'b0;
  bit [3:0]     resv_reg = 4'd0;

  cell_report_t pending_reports [$];
  cell_report_t next_report;
  int           errors = 0;
  bit           steady = 1'b0;
  int           hold_off_cycles = 0;
  int           in_gap = 0;
  bit           in_offered = 1'b0;

  function automatic int cols_used();
    return (cols_reg > NCOLS) ? NCOLS : int'(cols_reg);
  endfunction

  function automatic int rows_used();
    return (rows_reg > NROWS) ? NROWS : int'(rows_reg);
  endfunction

  function automatic int draw_gap();
    if (steady) return 0;
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 18));
    return int'($urandom_range(0, 2));
  endfunction

  // Applies one word to the predicted map and returns the report it should produce.
  function automatic cell_report_t predict_cell_report(logic cmd, logic sel, logic [3:0] col,
                                                       logic [3:0] row, logic full);
    cell_report_t rep;
    int nc, nr, p, r0, t, r, c, occ;
    rep = '0;
    nc = cols_used();
    nr = rows_used();
    if (cmd == CMD_WRITE) begin
      occ_map[sel][row][col] = full;
    end else begin
      for (t = 0; t < (dual_reg ? 2 : 1) && !rep.found; t++) begin
        p = start_plate_m ^ t;
        r0 = (p == 0) ? int'(resv_reg) : 0;
        for (r = r0; r < nr && !rep.found; r++) begin
          for (c = 0; c < nc && !rep.found; c++) begin
            if (!occ_map[p][r][c]) begin
              rep.found = 1'b1;
              rep.plate = p[0];
              rep.col = c[3:0];
              rep.row = r[3:0];
            end
          end
        end
      end
      if (rep.found) start_plate_m = rep.plate;
    end
    occ = 0;
    for (r = 0; r < nr; r++)
      for (c = 0; c < nc; c++)
        occ += occ_map[sel][r][c];
    rep.occupied = occ[COUNT_W-1:0];
    rep.vacant = COUNT_W'(nc * nr - occ);
    return rep;
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= 100) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_word(logic cmd, logic sel, logic [3:0] col, logic [3:0] row, logic full);
    // The valid line is already low whenever a gap is pending.
    repeat (in_gap) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.plate_sel <= sel;
    in_ch.cell_col <= col;
    in_ch.cell_row <= row;
    in_ch.cell_full <= full;
    do @(posedge clk); while (!in_ch.ready);
    pending_reports.push_back(predict_cell_report(cmd, sel, col, row, full));
    in_gap = draw_gap();
    in_offered = (in_gap == 0);
    if (!in_offered) in_ch.valid <= 1'b0;
  endtask

  task automatic stop_input();
    if (in_offered) in_ch.valid <= 1'b0;
    in_offered = 1'b0;
  endtask

  task automatic wait_drained();
    stop_input();
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COLUMNS:  cols_reg = val;
      CFG_ROWS:     rows_reg = val;
      CFG_DUAL:     dual_reg = val[0];
      CFG_RESERVED: resv_reg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [4:0] cols, logic [4:0] rows, logic dual, logic [3:0] resv);
    wait_drained();
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_DUAL, CFG_DATA_W'(dual));
    write_reg(CFG_RESERVED, CFG_DATA_W'(resv));
  endtask

  task automatic test_reset_state();
    send_word(CMD_SEARCH, 1'b0, 4'd0, 4'd0, 1'b0);
    send_word(CMD_WRITE, 1'b0, 4'd0, 4'd0, 1'b1);
    send_word(CMD_WRITE, 1'b1, 4'd15, 4'd15, 1'b1);
    send_word(CMD_SEARCH, 1'b1, 4'd15, 4'd15, 1'b1);
  endtask

  task automatic test_plate_switching();
    send_word(CMD_WRITE, 1'b0, 4'd1, 4'd0, 1'b1);
    send_word(CMD_SEARCH, 1'b0, 4'd0, 4'd0, 1'b0);
    send_word(CMD_WRITE, 1'b0, 4'd0, 4'd0, 1'b0);
    send_word(CMD_SEARCH, 1'b0, 4'd0, 4'd0, 1'b0);
    // Small dual-plate area with one reserved row: plate 0 fills up, so the hit moves over.
    set_config(5'd2, 5'd2, 1'b1, 4'd1);
    send_word(CMD_WRITE, 1'b0, 4'd0, 4'd1, 1'b1);
    send_word(CMD_WRITE, 1'b0, 4'd1, 4'd1, 1'b1);
    send_word(CMD_SEARCH, 1'b1, 4'd0, 4'd0, 1'b0);
    send_word(CMD_WRITE, 1'b0, 4'd0, 4'd1, 1'b0);
    send_word(CMD_SEARCH, 1'b0, 4'd0, 4'd0, 1'b0);
    send_word(CMD_WRITE, 1'b1, 4'd0, 4'd0, 1'b1);
    send_word(CMD_WRITE, 1'b1, 4'd1, 4'd0, 1'b1);
    send_word(CMD_WRITE, 1'b1, 4'd0, 4'd1, 1'b1);
    send_word(CMD_WRITE, 1'b1, 4'd1, 4'd1, 1'b1);
    send_word(CMD_SEARCH, 1'b1, 4'd0, 4'd0, 1'b0);
    send_word(CMD_WRITE, 1'b0, 4'd0, 4'd1, 1'b1);
    // Both plates are full now, so this search misses and keeps the start plate.
    send_word(CMD_SEARCH, 1'b0, 4'd0, 4'd0, 1'b0);
    set_config(5'd2, 5'd2, 1'b0, 4'd1);
    send_word(CMD_SEARCH, 1'b1, 4'd0, 4'd0, 1'b0);
  endtask

  task automatic test_size_extremes();
    set_config(5'd0, 5'd5, 1'b0, 4'd0);
    send_word(CMD_SEARCH, 1'b0, 4'd0, 4'd0, 1'b0);
    // Oversized settings saturate at the store size.
    set_config(5'd31, 5'd31, 1'b1, 4'd15);
    send_word(CMD_SEARCH, 1'b0, 4'd0, 4'd0, 1'b0);
    // Reserved rows beyond the in-use rows leave nothing to find on plate 0.
    set_config(5'd3, 5'd2, 1'b0, 4'd4);
    send_word(CMD_SEARCH, 1'b0, 4'd0, 4'd0, 1'b0);
    send_word(CMD_WRITE, 1'b1, 4'd15, 4'd15, 1'b0);
  endtask

  function automatic logic [4:0] pick_extent(int phase);
    case (phase % 4)
      0: return 5'($urandom_range(1, 5));
      1: return 5'($urandom_range(1, 16));
      2: begin
        case ($urandom_range(0, 4))
          0: return 5'd0;
          1: return 5'd1;
          2: return 5'd16;
          3: return 5'd17;
          default: return 5'd31;
        endcase
      end
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic test_random_traffic();
    int phase, n, kind, nc, nr;
    logic [3:0] resv;
    for (phase = 0; phase < 8; phase++) begin
      resv = ($urandom_range(0, 4) < 3) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      set_config(pick_extent(phase), pick_extent(phase), 1'($urandom), resv);
      steady = (phase == 5);
      nc = cols_used();
      nr = rows_used();
      for (n = 0; n < 100; n++) begin
        kind = int'($urandom_range(0, 99));
        if (kind < 30) begin
          send_word(CMD_SEARCH, 1'($urandom), 4'($urandom), 4'($urandom), 1'($urandom));
        end else if (kind < 85 && nc > 0 && nr > 0) begin
          // Mostly filling writes inside the in-use area, so searches have to dig deep.
          send_word(CMD_WRITE, 1'($urandom), 4'($urandom_range(0, nc - 1)),
                    4'($urandom_range(0, nr - 1)), $urandom_range(0, 3) != 0);
        end else begin
          send_word(CMD_WRITE, 1'($urandom), 4'($urandom), 4'($urandom), 1'($urandom));
        end
      end
      steady = 1'b0;
    end
  endtask

  task automatic test_output_stall();
    int n;
    set_config(5'd4, 5'd4, 1'b1, 4'd1);
    steady = 1'b1;
    hold_off_cycles = 300;
    for (n = 0; n < 25; n++) begin
      send_word(n % 3 == 0 ? CMD_SEARCH : CMD_WRITE, 1'($urandom), 4'($urandom_range(0, 4)),
                4'($urandom_range(0, 4)), 1'($urandom));
    end
    steady = 1'b0;
  endtask

  // Receiver: may hold ready low for a random stall, or once for hold_off_cycles, before taking each word.
  initial begin : result_drain
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result word with no word outstanding");
      end else begin
        next_report = pending_reports.pop_front();
        if (out_ch.found !== next_report.found)
          flag_mismatch($sformatf("found %0b, wanted %0b", out_ch.found, next_report.found));
        if (out_ch.found_plate !== next_report.plate)
          flag_mismatch($sformatf("found_plate %0b, wanted %0b", out_ch.found_plate,
                                  next_report.plate));
        if (out_ch.found_col !== next_report.col)
          flag_mismatch($sformatf("found_col %0d, wanted %0d", out_ch.found_col,
                                  next_report.col));
        if (out_ch.found_row !== next_report.row)
          flag_mismatch($sformatf("found_row %0d, wanted %0d", out_ch.found_row,
                                  next_report.row));
        if (out_ch.occupied_count !== next_report.occupied)
          flag_mismatch($sformatf("occupied_count %0d, wanted %0d", out_ch.occupied_count,
                                  next_report.occupied));
        if (out_ch.free_count !== next_report.vacant)
          flag_mismatch($sformatf("free_count %0d, wanted %0d", out_ch.free_count,
                                  next_report.vacant));
      end
    end
  end

  initial begin : run_limit
    #5000000;
    $display("[grid_first_free_cell_search_unit] ERROR");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_COLUMNS;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_WRITE;
    in_ch.plate_sel <= 1'b0;
    in_ch.cell_col <= 4'd0;
    in_ch.cell_row <= 4'd0;
    in_ch.cell_full <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_plate_switching();
    test_size_extremes();
    test_random_traffic();
    test_output_stall();
    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("[grid_first_free_cell_search_unit] OK");
    end else begin
      $display("[grid_first_free_cell_search_unit] ERROR");
    end
    $finish;
  end

endmodule
